[sv/tfr_pkg.sv]
// tfr_pkg: shared types, format codes and channel widening helpers for the
// texel-to-RGBA8 converter. No dependencies.
package tfr_pkg;

	// Texel layout codes held in the format register
	typedef enum logic [3:0] {
		FMT_RGB332   = 4'd0,
		FMT_A8       = 4'd2,
		FMT_I8       = 4'd3,
		FMT_AI44     = 4'd4,
		FMT_P8       = 4'd5,
		FMT_ARGB8332 = 4'd8,
		FMT_RGB565   = 4'd10,
		FMT_ARGB1555 = 4'd11,
		FMT_ARGB4444 = 4'd12,
		FMT_AI88     = 4'd13,
		FMT_AP88     = 4'd14
	} tfr_fmt_t;

	// Register index, taken from paddr[2]
	localparam logic REG_TEXEL_FORMAT   = 1'b0;
	localparam logic REG_PALETTE_ENABLE = 1'b1;

	localparam int PAL_DEPTH = 256;
	localparam int PAL_WIDTH = 32;

	// Command codes on the input channel
	localparam logic CMD_DECODE    = 1'b0;
	localparam logic CMD_PAL_WRITE = 1'b1;

	typedef struct packed {
		logic [3:0] texel_format;
		logic       palette_enable;
	} tfr_cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       bad_format;
	} tfr_pix_t;

	// Rounded widening to 8 bits, (v*255 + m/2)/m.
	// For 2, 3 and 4 bits bit replication gives exactly that value.
	function automatic logic [7:0] widen2(input logic [1:0] v);
		return {v, v, v, v};
	endfunction

	function automatic logic [7:0] widen3(input logic [2:0] v);
		return {v, v, v[2:1]};
	endfunction

	function automatic logic [7:0] widen4(input logic [3:0] v);
		return {v, v};
	endfunction

	// 5 bits: divide by 31 as multiply by ceil(2^18/31) and shift
	function automatic logic [7:0] widen5(input logic [4:0] v);
		logic [12:0] num;
		logic [26:0] prod;
		num  = 13'(v) * 13'd255 + 13'd15;
		prod = 27'(num) * 27'd8457;
		return prod[25:18];
	endfunction

	// 6 bits: divide by 63 as multiply by ceil(2^20/63) and shift
	function automatic logic [7:0] widen6(input logic [5:0] v);
		logic [13:0] num;
		logic [27:0] prod;
		num  = 14'(v) * 14'd255 + 14'd31;
		prod = 28'(num) * 28'd16645;
		return prod[27:20];
	endfunction

endpackage

[sv/tfr_ram.sv]
// tfr_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No dependencies.
module tfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/tfr_cfg.sv]
// tfr_cfg: APB register file for texel format and palette enable.
// Depends on tfr_pkg.
module tfr_cfg
	import tfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output tfr_cfg_t    cfg
);

	logic [3:0] texel_format_q;
	logic       palette_enable_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texel_format_q   <= '0;
			palette_enable_q <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_TEXEL_FORMAT:   texel_format_q   <= pwdata[3:0];
				REG_PALETTE_ENABLE: palette_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			REG_TEXEL_FORMAT:   prdata = {28'd0, texel_format_q};
			REG_PALETTE_ENABLE: prdata = {31'd0, palette_enable_q};
			default:            prdata = '0;
		endcase
	end

	assign cfg.texel_format   = texel_format_q;
	assign cfg.palette_enable = palette_enable_q;

endmodule

[sv/tfr_decode.sv]
// tfr_decode: per-format unpack and widening of one texel to RGBA8,
// palette lookup data comes in already read. Depends on tfr_pkg.
module tfr_decode
	import tfr_pkg::*;
(
	input  tfr_cfg_t        cfg,
	input  logic [15:0]     texel,
	input  logic [31:0]     pal_word,
	output tfr_pix_t        pix
);

	logic [7:0] lo;
	logic [7:0] hi;
	tfr_fmt_t   fmt;

	assign lo  = texel[7:0];
	assign hi  = texel[15:8];
	assign fmt = tfr_fmt_t'(cfg.texel_format);

	// format decoder
	always_comb begin
		pix.red        = '0;
		pix.green      = '0;
		pix.blue       = '0;
		pix.alpha      = 8'hFF;
		pix.bad_format = 1'b0;
		unique case (fmt)
			FMT_RGB332, FMT_ARGB8332: begin
				pix.red   = widen3(lo[7:5]);
				pix.green = widen3(lo[4:2]);
				pix.blue  = widen2(lo[1:0]);
				if (fmt == FMT_ARGB8332) begin
					pix.alpha = hi;
				end
			end
			FMT_A8: begin
				pix.red   = lo;
				pix.green = lo;
				pix.blue  = lo;
				pix.alpha = lo;
			end
			FMT_I8: begin
				pix.red   = lo;
				pix.green = lo;
				pix.blue  = lo;
			end
			FMT_AI44: begin
				pix.red   = widen4(lo[3:0]);
				pix.green = widen4(lo[3:0]);
				pix.blue  = widen4(lo[3:0]);
				pix.alpha = widen4(lo[7:4]);
			end
			FMT_P8: begin
				if (cfg.palette_enable) begin
					pix.red   = pal_word[7:0];
					pix.green = pal_word[15:8];
					pix.blue  = pal_word[23:16];
					pix.alpha = pal_word[31:24];
				end else begin
					pix.red   = lo;
					pix.green = lo;
					pix.blue  = lo;
				end
			end
			FMT_RGB565: begin
				pix.red   = widen5(texel[15:11]);
				pix.green = widen6(texel[10:5]);
				pix.blue  = widen5(texel[4:0]);
			end
			FMT_ARGB1555: begin
				pix.alpha = texel[15] ? 8'hFF : 8'h00;
				pix.red   = widen5(texel[14:10]);
				pix.green = widen5(texel[9:5]);
				pix.blue  = widen5(texel[4:0]);
			end
			FMT_ARGB4444: begin
				pix.alpha = widen4(texel[15:12]);
				pix.red   = widen4(texel[11:8]);
				pix.green = widen4(texel[7:4]);
				pix.blue  = widen4(texel[3:0]);
			end
			FMT_AI88: begin
				pix.red   = lo;
				pix.green = lo;
				pix.blue  = lo;
				pix.alpha = hi;
			end
			FMT_AP88: begin
				pix.alpha = hi;
				// black when the palette is off
				if (cfg.palette_enable) begin
					pix.red   = pal_word[7:0];
					pix.green = pal_word[15:8];
					pix.blue  = pal_word[23:16];
				end
			end
			default: begin
				pix.alpha      = '0;
				pix.bad_format = 1'b1;
			end
		endcase
	end

endmodule

[sv/texel_format_to_rgba8_top.sv]
// texel_format_to_rgba8_top: texel stream to RGBA8 converter, top level.
// Depends on tfr_pkg, tfr_cfg, tfr_ram, tfr_decode.
//
// Usage:
//   Input channel (texel_valid / texel_stall) carries one beat per item:
//   cmd 0 decodes texel_bits with the configured format, cmd 1 writes
//   palette_word into palette entry palette_index and gives no output.
//   Output channel (pixel_valid / pixel_stall) carries red, green, blue,
//   alpha, end_of_texture and bad_format for each decode beat, in order.
//   The APB port sets texel_format (0x0) and palette_enable (0x4); write
//   them only while the block is idle.
// Path: a decode beat is registered in stage 1 on accept, then in the output
//   register. Throughput: one beat per cycle unless stalled, set by the single
//   palette read port (address issued on accept, read data registered).
//   A palette write and a later read of the same entry never hit the RAM
//   at the same edge, so no forwarding is needed.
// Reset: arst_n clears both registers and the pipeline valids; the palette
//   contents are undefined until written.
// Stall: while pixel_stall holds a result, the one item behind it stays in
//   the middle stage; texel_stall rises only when both stages are full.
module texel_format_to_rgba8_top
	import tfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// texel input channel
	input  logic        texel_valid,
	output logic        texel_stall,
	input  logic        cmd,
	input  logic [15:0] texel_bits,
	input  logic [7:0]  palette_index,
	input  logic [31:0] palette_word,
	input  logic        last_texel,
	// pixel output channel
	output logic        pixel_valid,
	input  logic        pixel_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        end_of_texture,
	output logic        bad_format
);

	tfr_cfg_t    cfg;
	logic        in_acc;
	logic        out_adv;
	logic        s1_valid;
	logic [15:0] texel_s1;
	logic        last_s1;
	logic [31:0] pal_rdata;
	tfr_pix_t    pix;
	logic        out_valid_q;
	tfr_pix_t    pix_q;
	logic        eot_q;

	tfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake
	assign out_adv     = !out_valid_q || !pixel_stall;
	assign texel_stall = s1_valid && !out_adv;
	assign in_acc      = texel_valid && !texel_stall;

	// palette store: write on cmd 1 beats, read issued on decode beats
	tfr_ram #(
		.WIDTH (PAL_WIDTH),
		.DEPTH (PAL_DEPTH)
	) u_pal_ram (
		.clk   (clk),
		.we    (in_acc && (cmd == CMD_PAL_WRITE)),
		.waddr (palette_index),
		.wdata (palette_word),
		.re    (in_acc && (cmd == CMD_DECODE)),
		.raddr (texel_bits[7:0]),
		.rdata (pal_rdata)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_acc) begin
			s1_valid <= (cmd == CMD_DECODE);
		end else if (out_adv) begin
			s1_valid <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			texel_s1 <= texel_bits;
			last_s1  <= last_texel;
		end
	end

	tfr_decode u_decode (
		.cfg      (cfg),
		.texel    (texel_s1),
		.pal_word (pal_rdata),
		.pix      (pix)
	);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_adv && s1_valid) begin
			pix_q <= pix;
			eot_q <= last_s1;
		end
	end

	assign pixel_valid    = out_valid_q;
	assign red            = pix_q.red;
	assign green          = pix_q.green;
	assign blue           = pix_q.blue;
	assign alpha          = pix_q.alpha;
	assign bad_format     = pix_q.bad_format;
	assign end_of_texture = eot_q;

`ifndef SYNTHESIS
	// input is only held back when both stages are occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		texel_stall |-> (s1_valid && out_valid_q))
		else $error("texel_stall without a full pipeline");

	// a blocked middle stage keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !out_adv) |=> s1_valid)
		else $error("stage 1 item lost under stall");

	// palette writes never produce an output item
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd == CMD_PAL_WRITE)) |=> !s1_valid)
		else $error("palette write entered the decode stage");

	// unsupported format yields zero channels
	assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && bad_format) |->
			(red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0))
		else $error("bad_format with nonzero channels");
`endif

endmodule

[test/texel_format_to_rgba8_top_chk.sv]
// texel_format_to_rgba8_top_chk: monitor and scoreboard for the texel-to-RGBA8 converter.
// Tracks register writes and palette loads, predicts each pixel beat, compares in order.
// Depends on tfr_pkg.
module texel_format_to_rgba8_top_chk
	import tfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        texel_valid,
	input  logic        texel_stall,
	input  logic        cmd,
	input  logic [15:0] texel_bits,
	input  logic [7:0]  palette_index,
	input  logic [31:0] palette_word,
	input  logic        last_texel,
	input  logic        pixel_valid,
	input  logic        pixel_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	input  logic        end_of_texture,
	input  logic        bad_format,
	output int          fail_cnt,
	output int          pending_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		tfr_pix_t pix;
		logic     eot;
	} pixel_exp_t;

	// Shadow of the block's registers and palette
	logic [3:0]  fmt_reg;
	logic        pen_reg;
	logic [31:0] pal_mem [PAL_DEPTH];
	pixel_exp_t  pixel_exp_q [$];

	// Rounded widening of an m-bit-max channel to 8 bits, done arithmetically
	function automatic logic [7:0] scale_up(input int unsigned v, input int unsigned m);
		return 8'(((v & m) * 255 + m / 2) / m);
	endfunction

	function automatic pixel_exp_t decode_texel(input logic [3:0] fmt, input logic pen,
			input logic [15:0] t, input logic eot);
		pixel_exp_t  o;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [31:0] entry;
		lo = t[7:0];
		hi = t[15:8];
		o = '0;
		o.pix.alpha = 8'hFF;
		o.eot = eot;
		case (fmt)
			FMT_RGB332, FMT_ARGB8332: begin
				o.pix.red   = scale_up(lo >> 5, 7);
				o.pix.green = scale_up(lo >> 2, 7);
				o.pix.blue  = scale_up(lo, 3);
				if (fmt == FMT_ARGB8332)
					o.pix.alpha = hi;
			end
			FMT_A8: begin
				o.pix.red   = lo;
				o.pix.green = lo;
				o.pix.blue  = lo;
				o.pix.alpha = lo;
			end
			FMT_I8: begin
				o.pix.red   = lo;
				o.pix.green = lo;
				o.pix.blue  = lo;
			end
			FMT_AI44: begin
				o.pix.red   = scale_up(lo, 15);
				o.pix.green = scale_up(lo, 15);
				o.pix.blue  = scale_up(lo, 15);
				o.pix.alpha = scale_up(lo >> 4, 15);
			end
			FMT_P8: begin
				if (pen) begin
					entry = pal_mem[lo];
					{o.pix.alpha, o.pix.blue, o.pix.green, o.pix.red} = entry;
				end else begin
					// no palette: grey ramp, opaque
					o.pix.red   = lo;
					o.pix.green = lo;
					o.pix.blue  = lo;
				end
			end
			FMT_RGB565: begin
				o.pix.red   = scale_up(t >> 11, 31);
				o.pix.green = scale_up(t >> 5, 63);
				o.pix.blue  = scale_up(t, 31);
			end
			FMT_ARGB1555: begin
				o.pix.alpha = t[15] ? 8'hFF : 8'h00;
				o.pix.red   = scale_up(t >> 10, 31);
				o.pix.green = scale_up(t >> 5, 31);
				o.pix.blue  = scale_up(t, 31);
			end
			FMT_ARGB4444: begin
				o.pix.alpha = scale_up(t >> 12, 15);
				o.pix.red   = scale_up(t >> 8, 15);
				o.pix.green = scale_up(t >> 4, 15);
				o.pix.blue  = scale_up(t, 15);
			end
			FMT_AI88: begin
				o.pix.red   = lo;
				o.pix.green = lo;
				o.pix.blue  = lo;
				o.pix.alpha = hi;
			end
			FMT_AP88: begin
				// color from palette when enabled, black otherwise
				o.pix.alpha = hi;
				if (pen) begin
					entry = pal_mem[lo];
					{o.pix.blue, o.pix.green, o.pix.red} = entry[23:0];
				end
			end
			default: begin
				o.pix.bad_format = 1'b1;
				o.pix.alpha = 8'h00;
			end
		endcase
		return o;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_cnt++;
		end
	endtask

	// Observe all three ports at each edge
	always @(posedge clk or negedge arst_n) begin
		pixel_exp_t want;
		if (!arst_n) begin
			fmt_reg = '0;
			pen_reg = 1'b0;
			pixel_exp_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_TEXEL_FORMAT)
					fmt_reg = pwdata[3:0];
				else
					pen_reg = pwdata[0];
			end

			// pixel beat: compare with the oldest prediction
			if (pixel_valid && !pixel_stall) begin
				if (pixel_exp_q.size() == 0) begin
					$error("pixel beat with no texel outstanding");
					fail_cnt++;
				end else begin
					want = pixel_exp_q.pop_front();
					check_field("red", want.pix.red, red);
					check_field("green", want.pix.green, green);
					check_field("blue", want.pix.blue, blue);
					check_field("alpha", want.pix.alpha, alpha);
					check_field("end_of_texture", 8'(want.eot), 8'(end_of_texture));
					check_field("bad_format", 8'(want.pix.bad_format), 8'(bad_format));
				end
			end

			// texel beat: palette load or decode
			if (texel_valid && !texel_stall) begin
				if (cmd == CMD_PAL_WRITE)
					pal_mem[palette_index] = palette_word;
				else
					pixel_exp_q.push_back(decode_texel(fmt_reg, pen_reg, texel_bits, last_texel));
			end
		end
		pending_cnt = pixel_exp_q.size();
	end

endmodule

[test/texel_format_to_rgba8_top_tb.sv]
// texel_format_to_rgba8_top_tb: stimulus and verdict for the texel-to-RGBA8 converter.
// Walks all formats with palette on and off, with random beats and stalls.
// Depends on tfr_pkg, texel_format_to_rgba8_top and texel_format_to_rgba8_top_chk.
module texel_format_to_rgba8_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tfr_pkg::*;

	// Format codes the block rejects
	localparam logic [3:0] FMT_BAD_LOW  = 4'd1;
	localparam logic [3:0] FMT_BAD_HIGH = 4'd15;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int NUM_PHASES  = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        texel_valid;
	logic        texel_stall;
	logic        cmd;
	logic [15:0] texel_bits;
	logic [7:0]  palette_index;
	logic [31:0] palette_word;
	logic        last_texel;
	logic        pixel_valid;
	logic        pixel_stall;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        end_of_texture;
	logic        bad_format;
	int          fail_cnt;
	int          pending_cnt;
	int          quiet_cycles;

	// Palette entries loaded so far; indexed reads only target these
	bit          pal_loaded [PAL_DEPTH];
	logic [7:0]  pal_pool [$];
	logic [3:0]  cur_fmt;
	bit          calm;
	bit          hold_go;
	bit          hold_done;

	texel_format_to_rgba8_top DUT (.*);

	texel_format_to_rgba8_top_chk CHK (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: no beat on any port for too long
	always @(posedge clk) begin
		if (!arst_n || (texel_valid && !texel_stall) || (pixel_valid && !pixel_stall)
				|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Pixel side: random stall bursts, one long hold, none when calm
	initial begin
		pixel_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_go && !hold_done) begin
				pixel_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				pixel_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				pixel_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// One texel beat, with an optional idle burst ahead of it
	task automatic send_beat(input logic c, input logic [15:0] bits, input logic [7:0] idx,
			input logic [31:0] word, input logic last);
		if (!calm && $urandom_range(0, 4) == 0) begin
			texel_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		texel_valid   <= 1'b1;
		cmd           <= c;
		texel_bits    <= bits;
		palette_index <= idx;
		palette_word  <= word;
		last_texel    <= last;
		do @(posedge clk); while (texel_stall);
	endtask

	task automatic pal_load(input logic [7:0] idx, input logic [31:0] word);
		if (!pal_loaded[idx]) begin
			pal_loaded[idx] = 1'b1;
			pal_pool.push_back(idx);
		end
		send_beat(CMD_PAL_WRITE, 16'($urandom), idx, word, 1'($urandom));
	endtask

	task automatic decode(input logic [15:0] bits, input logic last);
		send_beat(CMD_DECODE, bits, 8'($urandom), $urandom, last);
	endtask

	// Drain: every pixel out, then a short wait for a trailing palette load
	task automatic settle();
		texel_valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write; psel is left high so writes can go back to back
	task automatic reg_write(input logic idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_mode(input logic [3:0] fmt, input logic pen);
		settle();
		reg_write(REG_TEXEL_FORMAT, ($urandom & ~32'hF) | 32'(fmt));
		reg_write(REG_PALETTE_ENABLE, ($urandom & ~32'h1) | 32'(pen));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_fmt = fmt;
	endtask

	// Random beat: mostly decodes, some palette loads
	task automatic rand_item();
		logic [15:0] bits;
		logic [7:0]  idx;
		if ($urandom_range(0, 4) == 0 || pal_pool.size() < 8) begin
			case ($urandom_range(0, 5))
				0: idx = 8'h00;
				1: idx = 8'hFF;
				default: idx = 8'($urandom);
			endcase
			pal_load(idx, $urandom);
		end else begin
			bits = 16'($urandom);
			if (cur_fmt == FMT_P8 || cur_fmt == FMT_AP88)
				bits[7:0] = pal_pool[$urandom_range(0, pal_pool.size() - 1)];
			decode(bits, $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		texel_valid   <= 1'b0;
		cmd           <= CMD_DECODE;
		texel_bits    <= '0;
		palette_index <= '0;
		palette_word  <= '0;
		last_texel    <= 1'b0;
		calm      = 1'b0;
		hold_go   = 1'b0;
		hold_done = 1'b0;
		cur_fmt   = FMT_RGB332;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, ignored high byte, palette loads
		set_mode(FMT_RGB332, 1'b0);
		decode(16'h0000, 1'b0);
		decode(16'hFFFF, 1'b1);
		decode(16'hFF00, 1'b0);
		pal_load(8'h00, 32'h0000_0000);
		pal_load(8'hFF, 32'hFFFF_FFFF);
		pal_load(8'h5A, 32'hA5C3_3C5A);
		// indexed formats without and with the palette
		set_mode(FMT_P8, 1'b0);
		decode(16'h12FF, 1'b0);
		decode(16'hAB00, 1'b1);
		set_mode(FMT_P8, 1'b1);
		decode(16'hFFFF, 1'b0);
		decode(16'h005A, 1'b0);
		decode(16'h0000, 1'b1);
		set_mode(FMT_AP88, 1'b0);
		decode(16'hC35A, 1'b0);
		set_mode(FMT_AP88, 1'b1);
		decode(16'h80FF, 1'b0);
		decode(16'h7F5A, 1'b1);
		// rejected codes still pass last_texel through
		set_mode(FMT_BAD_HIGH, 1'b1);
		decode(16'hFFFF, 1'b1);
		set_mode(FMT_BAD_LOW, 1'b0);
		decode(16'h0000, 1'b0);
		set_mode(FMT_RGB565, 1'b0);
		decode(16'hFFFF, 1'b0);
		decode(16'h0000, 1'b1);
		set_mode(FMT_ARGB1555, 1'b1);
		decode(16'h8000, 1'b0);
		decode(16'h7FFF, 1'b0);

		// Random: every code once in order, then random settings
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			calm = (ph >= NUM_PHASES - 4);
			if (ph == 12)
				hold_go = 1'b1;
			if (ph < 16)
				set_mode(4'(ph), 1'(ph));
			else
				set_mode(4'($urandom), 1'($urandom));
			repeat ($urandom_range(15, 28)) rand_item();
		end

		settle();
		if (fail_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
